// ----- rtl/pixel_contrast_brightness_gamma_defines.svh -----
// Assertion macros shared by the pixel adjust RTL.
`ifndef PIXEL_CONTRAST_BRIGHTNESS_GAMMA_DEFINES_SVH
`define PIXEL_CONTRAST_BRIGHTNESS_GAMMA_DEFINES_SVH

// Checked at every clock edge outside reset.
`define PCBG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PCBG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/pcbg_pkg.sv -----
// Shared types, constants and elaboration-time functions of the pixel adjust block.
package pcbg_pkg;

   localparam int LOG_FRAC  = 30;
   localparam int LOG_STEPS = 30;
   // linear (2) + normalize (1) + log2 steps + log scale (2) + exp2 steps + round (1)
   localparam int LATENCY   = 3 + LOG_STEPS + 2 + LOG_STEPS + 1;

   localparam logic [2:0] REG_ADJUST_ENABLE  = 3'd0;
   localparam logic [2:0] REG_HDR_MODE       = 3'd1;
   localparam logic [2:0] REG_CONTRAST_GAIN  = 3'd2;
   localparam logic [2:0] REG_LEVEL_OFFSET   = 3'd3;
   localparam logic [2:0] REG_GAMMA_EXPONENT = 3'd4;

   typedef struct packed {
      logic               adjust;
      logic               hdr;
      logic [19:0]        gain;
      logic signed [19:0] offset;
      logic [18:0]        expo;
   } cfg_type;

   // floor(sqrt(val)), bit by bit
   function automatic logic [63:0] isqrt(input logic [63:0] val);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] probe;
      rem   = val;
      res   = '0;
      probe = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q30, each square root floored as the chain goes
   function automatic logic [30:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'h0000_0000_8000_0000;
      for (int j = 0; j < k; j++) begin
         r = isqrt(r << LOG_FRAC);
      end
      return r[30:0];
   endfunction

endpackage

// ----- rtl/pcbg_log_step.sv -----
// One squaring step of the log2 fraction: one result bit per stage.
module pcbg_log_step (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] m_i,
   input  logic [29:0] frac_i,
   output logic [30:0] m_o,
   output logic [29:0] frac_o
);

   logic [61:0] sq;
   logic [31:0] top;
   logic [30:0] m_in;
   logic [29:0] frac_in;
   logic [30:0] m_ff;
   logic [29:0] frac_ff;

   always_comb begin
      sq  = 62'(m_i) * 62'(m_i);
      top = sq[61:30];
      if (top[31]) begin
         m_in    = top[31:1];
         frac_in = {frac_i[28:0], 1'b1};
      end else begin
         m_in    = top[30:0];
         frac_in = {frac_i[28:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= m_in;
         frac_ff <= frac_in;
      end
   end

   assign m_o    = m_ff;
   assign frac_o = frac_ff;

endmodule

// ----- rtl/pcbg_exp_step.sv -----
// One root-of-two multiply step of exp2, steered by the top fraction bit.
module pcbg_exp_step (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] root,
   input  logic [30:0] res_i,
   input  logic [29:0] f_i,
   output logic [30:0] res_o,
   output logic [29:0] f_o
);

   logic [61:0] prod;
   logic [30:0] res_in;
   logic [30:0] res_ff;
   logic [29:0] f_ff;

   always_comb begin
      prod   = 62'(res_i) * 62'(root);
      res_in = f_i[29] ? prod[60:30] : res_i;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         f_ff   <= {f_i[28:0], 1'b0};
      end
   end

   assign res_o = res_ff;
   assign f_o   = f_ff;

endmodule

// ----- rtl/pcbg_channel.sv -----
// Full per-channel datapath: gain/offset, clamp, log2, scale, exp2, round.
module pcbg_channel #(
   parameter int FRAC_BITS = 12
) (
   input  logic             clock,
   input  logic             en,
   input  pcbg_pkg::cfg_type cfg,
   input  logic [15:0]      ch_i,
   output logic [15:0]      ch_o
);

   localparam int STEPS = pcbg_pkg::LOG_STEPS;
   localparam logic [15:0] UNIT_TOP =
      (FRAC_BITS >= 16) ? 16'hFFFF : 16'(32'd1 << FRAC_BITS);
   localparam logic signed [35:0] LG_BIAS = 36'(FRAC_BITS) <<< pcbg_pkg::LOG_FRAC;
   localparam logic signed [55:0] Z_BIAS  = 56'(FRAC_BITS) <<< pcbg_pkg::LOG_FRAC;
   localparam logic signed [38:0] HALF    = 39'(32'd1 << (FRAC_BITS - 1));
   localparam logic [18:0]        EXP_ONE = 19'(32'd1 << FRAC_BITS);

   typedef struct packed {
      logic [15:0] ch;
      logic [15:0] v;
      logic        zero;
      logic [3:0]  msb;
   } lside_type;

   typedef struct packed {
      logic [15:0] ch;
      logic [15:0] v;
      logic        zero;
      logic        big;
      logic        tiny;
      logic [4:0]  shift;
   } eside_type;

   // stage 1: product
   logic [35:0] prod1_ff;
   logic [15:0] ch1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= 36'(ch_i) * 36'(cfg.gain);
         ch1_ff   <= ch_i;
      end
   end

   // stage 2: offset, round, clamp
   logic signed [38:0] acc;
   logic signed [38:0] vs;
   logic [15:0]        lim;
   logic [15:0]        v2_in;
   logic [15:0]        v2_ff;
   logic [15:0]        ch2_ff;

   always_comb begin
      acc = $signed({3'b000, prod1_ff})
          + ($signed({{19{cfg.offset[19]}}, cfg.offset}) <<< FRAC_BITS) + HALF;
      vs  = acc >>> FRAC_BITS;
      lim = cfg.hdr ? 16'hFFFF : UNIT_TOP;
      if (vs < 0) begin
         v2_in = '0;
      end else if (vs > $signed({23'b0, lim})) begin
         v2_in = lim;
      end else begin
         v2_in = vs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v2_ff  <= v2_in;
         ch2_ff <= ch1_ff;
      end
   end

   // stage 3: normalize into [1, 2) Q30
   logic [3:0]  msb3;
   logic [45:0] wide3;
   logic [30:0] lm [0:STEPS];
   logic [29:0] lf [0:STEPS];
   lside_type   lside [0:STEPS];
   logic [30:0] m3_ff;

   always_comb begin
      msb3 = '0;
      for (int i = 0; i < 16; i++) begin
         if (v2_ff[i]) msb3 = 4'(i);
      end
      wide3 = {v2_ff, 30'b0} >> msb3;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff         <= wide3[30:0];
         lside[0].ch   <= ch2_ff;
         lside[0].v    <= v2_ff;
         lside[0].zero <= (v2_ff == '0);
         lside[0].msb  <= msb3;
      end
   end

   assign lm[0] = m3_ff;
   assign lf[0] = '0;

   for (genvar g = 0; g < STEPS; g++) begin : g_log
      pcbg_log_step u_step (
         .clock  (clock),
         .en     (en),
         .m_i    (lm[g]),
         .frac_i (lf[g]),
         .m_o    (lm[g+1]),
         .frac_o (lf[g+1])
      );
      always_ff @(posedge clock) begin
         if (en) lside[g+1] <= lside[g];
      end
   end

   // log scale stage A: lg = log2(v) - F, split product with the exponent
   logic signed [35:0] lg;
   logic [36:0]        plo_ff;
   logic signed [37:0] phi_ff;
   lside_type          sa_ff;

   always_comb begin
      lg = $signed({2'b00, lside[STEPS].msb, lf[STEPS]}) - LG_BIAS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= 37'(lg[17:0]) * 37'(cfg.expo);
         phi_ff <= 38'($signed(lg[35:18])) * 38'($signed({1'b0, cfg.expo}));
         sa_ff  <= lside[STEPS];
      end
   end

   // log scale stage B: floor to Q30, integer part and fraction
   logic signed [55:0] prod_b;
   logic signed [55:0] zb;
   logic signed [25:0] nb;
   logic [30:0]        em [0:STEPS];
   logic [29:0]        ef [0:STEPS];
   eside_type          eside [0:STEPS];
   logic [29:0]        fb_ff;

   always_comb begin
      prod_b = (56'(phi_ff) <<< 18) + $signed({19'b0, plo_ff});
      zb     = (prod_b >>> FRAC_BITS) + Z_BIAS;
      nb     = zb[55:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fb_ff          <= zb[29:0];
         eside[0].ch    <= sa_ff.ch;
         eside[0].v     <= sa_ff.v;
         eside[0].zero  <= sa_ff.zero;
         eside[0].big   <= (nb > 26'sd16);
         eside[0].tiny  <= (nb < -26'sd1);
         eside[0].shift <= 5'(26'sd30 - nb);
      end
   end

   assign em[0] = 31'h4000_0000;
   assign ef[0] = fb_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_exp
      localparam logic [30:0] ROOT = pcbg_pkg::root_q30(k + 1);
      pcbg_exp_step u_step (
         .clock (clock),
         .en    (en),
         .root  (ROOT),
         .res_i (em[k]),
         .f_i   (ef[k]),
         .res_o (em[k+1]),
         .f_o   (ef[k+1])
      );
      always_ff @(posedge clock) begin
         if (en) eside[k+1] <= eside[k];
      end
   end

   // final: round to the pixel format, saturate, select
   logic [31:0] rsum;
   logic [31:0] rnd;
   logic [15:0] pw;
   logic [15:0] out_in;
   logic [15:0] out_ff;
   eside_type   ef_side;

   always_comb begin
      ef_side = eside[STEPS];
      rsum    = 32'(em[STEPS]) + (32'd1 << (ef_side.shift - 5'd1));
      rnd     = rsum >> ef_side.shift;
      priority if (ef_side.zero) pw = '0;
      else if (ef_side.big)      pw = 16'hFFFF;
      else if (ef_side.tiny)     pw = '0;
      else if (rnd > 32'd65535)  pw = 16'hFFFF;
      else                       pw = rnd[15:0];

      priority if (!cfg.adjust)      out_in = ef_side.ch;
      else if (cfg.expo == EXP_ONE)  out_in = ef_side.v;
      else                           out_in = pw;
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   assign ch_o = out_ff;

endmodule

// ----- rtl/pixel_contrast_brightness_gamma.sv -----
// Top level of the RGBA brightness / contrast / gamma pixel adjuster.
// Each color channel becomes channel*gain + offset (8.12 gain, signed 8.12 offset),
// rounded to 4.12 and clamped to [0,1.0] (or floored at 0 and saturated at the format
// maximum in HDR mode), then raised to the gamma exponent as exp2(exp*log2(x)) with
// zero kept at zero; an exponent of exactly 1.0 skips the power. Alpha is copied.
// With adjust_enable low the pixel comes out unchanged. One pixel transaction is
// taken per clock while the sink keeps up; every pixel passes the pipeline (30 squaring
// stages for log2, 30 root-multiply stages for exp2, six stages for the linear part,
// scaling and rounding), so the rate is one pixel per clock unless the sink stalls it.
// An input skid register lets one more transaction in while a result is held by the
// sink. Registers are written through csr_we/csr_index/csr_wdata and must only change
// while no pixels are in flight.
module pixel_contrast_brightness_gamma #(
   parameter int FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // pixel in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // red_in, green_in, blue_in, alpha_in (16 b each)
   // pixel out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out (16 b each)
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

`include "pixel_contrast_brightness_gamma_defines.svh"

   localparam int LAT = pcbg_pkg::LATENCY;

   // configuration registers
   pcbg_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adjust <= 1'b0;
         cfg_ff.hdr    <= 1'b0;
         cfg_ff.gain   <= 20'(32'd1 << FRAC_BITS);
         cfg_ff.offset <= '0;
         cfg_ff.expo   <= 19'(32'd1 << FRAC_BITS);
      end else if (csr_we) begin
         unique case (csr_index)
            pcbg_pkg::REG_ADJUST_ENABLE:  cfg_ff.adjust <= csr_wdata[0];
            pcbg_pkg::REG_HDR_MODE:       cfg_ff.hdr    <= csr_wdata[0];
            pcbg_pkg::REG_CONTRAST_GAIN:  cfg_ff.gain   <= csr_wdata;
            pcbg_pkg::REG_LEVEL_OFFSET:   cfg_ff.offset <= csr_wdata;
            pcbg_pkg::REG_GAMMA_EXPONENT: cfg_ff.expo   <= csr_wdata[18:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output slot is free or being drained
   logic             pipe_en;
   logic [LAT-1:0]   valid_ff;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   logic [63:0]      skid_data_ff;
   logic             accept;
   logic             src_valid;
   logic [63:0]      src_data;

   assign pipe_en    = rsp_tready || !valid_ff[LAT-1];
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign src_valid  = skid_valid_ff || accept;
   assign src_data   = skid_valid_ff ? skid_data_ff : req_tdata;

   // skid: holds a transaction taken while the pipeline is stalled
   always_comb begin
      skid_valid_in = pipe_en ? 1'b0 : src_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) skid_valid_ff <= 1'b0;
      else       skid_valid_ff <= skid_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept && !pipe_en) skid_data_ff <= req_tdata;
   end

   // valid bits ride alongside the channel pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[LAT-2:0], src_valid};
      end
   end

   // alpha delay line
   logic [15:0] alpha_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         alpha_ff[0] <= src_data[63:48];
         for (int i = 1; i < LAT; i++) alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   logic [15:0] chan_out [0:2];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      pcbg_channel #(
         .FRAC_BITS (FRAC_BITS)
      ) u_chan (
         .clock (clock),
         .en    (pipe_en),
         .cfg   (cfg_ff),
         .ch_i  (src_data[16*c +: 16]),
         .ch_o  (chan_out[c])
      );
   end

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {alpha_ff[LAT-1], chan_out[2], chan_out[1], chan_out[0]};

   `PCBG_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_tvalid && req_tready), "reset left a transaction pending")
   `PCBG_ASSERT(a_skid_holds, (skid_valid_ff && !pipe_en) |=> (skid_valid_ff && $stable(skid_data_ff)), "skid content lost during stall")
   `PCBG_ASSERT(a_stall_freezes, !pipe_en |=> $stable(valid_ff), "valid line moved during stall")
   `PCBG_ASSERT(a_no_skid_when_moving, ($past(pipe_en) && !$past(reset)) |-> !skid_valid_ff, "skid filled while pipeline advanced")

endmodule

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the RGBA brightness/contrast/gamma pixel adjuster.
module testbench;

   localparam int FRAC = 12;
   localparam int LOG_FRAC = pcbg_pkg::LOG_FRAC;
   localparam longint unsigned QONE = 64'd1 << LOG_FRAC;

   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // red, green, blue, alpha (16 b each, red lowest)
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // red, green, blue, alpha (16 b each, red lowest)
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [19:0] csr_wdata;

   pixel_contrast_brightness_gamma dut (.*);

   // shadow copy of the register file
   logic               adj_on;
   logic               hdr_on;
   logic [19:0]        gain_reg;
   logic signed [19:0] offset_reg;
   logic [18:0]        expo_reg;

   longint unsigned root_chain [1:30];   // 2^(2^-k) in Q30
   pixel_type pending_pixels [$];
   pixel_type expected_pixels [$];
   int        send_idle_pct;
   int        recv_idle_pct;
   int        error_count;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned res, probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // log2 in Q30, fraction found by repeated squaring
   function automatic longint log2_fixed(input int unsigned x);
      int              msb;
      longint unsigned m, frac;
      msb  = 0;
      frac = 0;
      while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
      m = (longint'(x) << LOG_FRAC) >> msb;
      for (int i = 1; i <= LOG_FRAC; i++) begin
         m = (m * m) >> LOG_FRAC;
         if (m >= 2 * QONE) begin
            m >>= 1;
            frac |= 64'd1 << (LOG_FRAC - i);
         end
      end
      return longint'(msb) * longint'(QONE) + longint'(frac);
   endfunction

   function automatic longint unsigned exp2_fixed(input longint unsigned f);
      longint unsigned res;
      res = QONE;
      for (int k = 1; k <= LOG_FRAC; k++)
         if ((f >> (LOG_FRAC - k)) & 1) res = (res * root_chain[k]) >> LOG_FRAC;
      return res;
   endfunction

   function automatic logic [15:0] raise_power(input int unsigned x);
      longint          lg, y, z, n, sh;
      longint unsigned mant;
      if (x == 0) return 16'd0;   // zero stays zero
      lg   = log2_fixed(x) - longint'(FRAC) * longint'(QONE);
      y    = (lg * longint'(expo_reg)) >>> FRAC;
      z    = y + longint'(FRAC) * longint'(QONE);
      n    = z >>> LOG_FRAC;
      mant = exp2_fixed(longint'(z - (n << LOG_FRAC)));
      if (n > 16) return 16'hFFFF;
      sh = LOG_FRAC - n;
      if (sh >= 32) return 16'd0;
      mant = (mant + (64'd1 << (sh - 1))) >> sh;
      if (mant > 65535) mant = 65535;
      return mant[15:0];
   endfunction

   function automatic logic [15:0] adjust_color(input logic [15:0] ch);
      longint acc, v, top;
      acc = longint'(ch) * longint'(gain_reg) + longint'(offset_reg) * (longint'(1) << FRAC);
      v   = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
      top = hdr_on ? 65535 : (longint'(1) << FRAC);
      if (v < 0) v = 0;
      if (v > top) v = top;
      if (expo_reg == (19'd1 << FRAC)) return v[15:0];   // unity gamma skips the power
      return raise_power(v[31:0]);
   endfunction

   function automatic pixel_type adjusted_pixel(input pixel_type p);
      pixel_type q;
      q = p;
      if (adj_on) begin
         q.red   = adjust_color(p.red);
         q.green = adjust_color(p.green);
         q.blue  = adjust_color(p.blue);
      end
      return q;
   endfunction

   // driver: holds data while stalled, pulls from the pending queue otherwise
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_pixels.insert(expected_pixels.size(), adjusted_pixel(req_tdata));
         if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_pixels.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: random backpressure, compares each result transaction
   always @(posedge clock) begin
      pixel_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red) begin
                  $error("red_out expected %h got %h", want.red, got.red);
                  error_count++;
               end
               if (got.green !== want.green) begin
                  $error("green_out expected %h got %h", want.green, got.green);
                  error_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue_out expected %h got %h", want.blue, got.blue);
                  error_count++;
               end
               if (got.alpha !== want.alpha) begin
                  $error("alpha_out expected %h got %h", want.alpha, got.alpha);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic write_settings(input logic en, input logic hdr, input logic [19:0] gain,
                                 input logic [19:0] offs, input logic [18:0] expo);
      logic [19:0] vals [5];
      vals = '{20'(en), 20'(hdr), gain, offs, 20'(expo)};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we     <= 1'b0;
      adj_on     = en;
      hdr_on     = hdr;
      gain_reg   = gain;
      offset_reg = offs;
      expo_reg   = expo;
   endtask

   task automatic wait_drained();
      while (pending_pixels.size() > 0 || req_tvalid || expected_pixels.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic [15:0] random_channel();
      case ($urandom_range(5))
         0:       return 16'($urandom);
         1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         2:       return 16'($urandom_range(4200, 3990));
         default: return 16'($urandom_range(5000));
      endcase
   endfunction

   task automatic queue_pixel(input logic [15:0] r, g, b, a);
      pixel_type p;
      p = '{alpha: a, blue: b, green: g, red: r};
      pending_pixels.insert(pending_pixels.size(), p);
   endtask

   initial begin
      longint unsigned r;
      logic [19:0]     gain, offs;
      logic [18:0]     expo;
      int              phase_count;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = pcbg_pkg::REG_ADJUST_ENABLE;
      csr_wdata     = '0;
      error_count   = 0;
      send_idle_pct = 17;
      recv_idle_pct = 58;
      adj_on = 0; hdr_on = 0; gain_reg = 20'd4096; offset_reg = 0; expo_reg = 19'd4096;
      r = 2 * QONE;
      for (int k = 1; k <= 30; k++) begin
         r = floor_sqrt(r << LOG_FRAC);
         root_chain[k] = r;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: pass-through at reset settings
      queue_pixel(16'h0000, 16'hFFFF, 16'h1000, 16'hA5A5);
      queue_pixel(16'hFFFF, 16'h0001, 16'h0000, 16'h5A5A);
      wait_drained();
      // gamma about 1/2.2, unit clamp: zero, tiny, one, above one
      write_settings(1, 0, 20'd4096, 20'd0, 19'd1862);
      queue_pixel(16'h0000, 16'h0001, 16'h1000, 16'hFFFF);
      queue_pixel(16'hFFFF, 16'h0800, 16'h1001, 16'h0000);
      queue_pixel(16'h0002, 16'h0FFF, 16'h0400, 16'h1234);
      wait_drained();
      // HDR: high gain saturates at format max, unity gamma bypass
      write_settings(1, 1, 20'hFFFFF, 20'd0, 19'd4096);
      queue_pixel(16'hFFFF, 16'h0001, 16'h0000, 16'h8000);
      queue_pixel(16'h1000, 16'h0010, 16'h7FFF, 16'h0001);
      wait_drained();
      // most negative offset floors at zero; smallest exponent
      write_settings(1, 1, 20'd0, 20'h80000, 19'd1);
      queue_pixel(16'hFFFF, 16'h1000, 16'h0000, 16'h00FF);
      wait_drained();
      write_settings(1, 1, 20'd4096, 20'h7FFFF, 19'd1);
      queue_pixel(16'hFFFF, 16'h0000, 16'h1000, 16'hFF00);
      wait_drained();
      // exponent of 100.0, the top of the random range, with HDR values above one
      write_settings(1, 1, 20'd4096, 20'd0, 19'd409600);
      queue_pixel(16'h1001, 16'h0FFF, 16'h2000, 16'h0F0F);
      queue_pixel(16'hFFFF, 16'h0001, 16'h1000, 16'hF0F0);
      wait_drained();

      // random phases with varied settings; idling pattern changes per third
      phase_count = 9;
      for (int ph = 0; ph < phase_count; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 17; recv_idle_pct = 58;
         end else if (ph < 6) begin
            send_idle_pct = 58; recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;  recv_idle_pct = 0;
         end
         gain = $urandom_range(1) ? 20'($urandom_range(16384)) : 20'($urandom);
         offs = $urandom_range(1) ? 20'($signed($urandom_range(8192)) - 4096) : 20'($urandom);
         case (ph % 3)
            0:       expo = 19'd4096;
            1:       expo = 19'($urandom_range(8192, 1));
            default: expo = 19'($urandom_range(409600, 1));
         endcase
         write_settings(ph != 4, ph[0], gain, offs, expo);
         repeat (93) queue_pixel(random_channel(), random_channel(), random_channel(),
                                 16'($urandom));
         wait_drained();
      end

      repeat (pcbg_pkg::LATENCY + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pcbg_pkg.sv
rtl/pcbg_log_step.sv
rtl/pcbg_exp_step.sv
rtl/pcbg_channel.sv
rtl/pixel_contrast_brightness_gamma.sv
tb/testbench.sv
